[rtl/clre_pkg.sv]
// clre_pkg: shared types, codes and constant tables for the character lcd refresh engine
// no dependencies; used by clre_ctrl, clre_datapath and char_lcd_refresh_engine

package clre_pkg;

   // field widths fixed by the interface
   localparam int MODE_W = 3;
   localparam int POS_W = 7;
   localparam int BYTE_W = 8;
   localparam int WAIT_W = 18;
   localparam int STEP_W = 3;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_REFRESH = 3'd2,
      MODE_CLEAR   = 3'd3,
      MODE_INIT    = 3'd4
   } mode_type;

   // controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_FETCH,
      CTL_INIT
   } ctl_state_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      DP_NOP,
      DP_WRITE_CHAR,
      DP_START_REFRESH,
      DP_CLEAR,
      DP_SEND_PENDING,
      DP_FETCH,
      DP_SEND_DATA,
      DP_SEND_INIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic              power_on;
      logic [STEP_W-1:0] init_step;
   } dp_cmd_type;

   typedef struct packed {
      logic refresh_active;
      logic cmd_pending;
      logic powered_on;
   } dp_status_type;

   // display bytes
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_LINE0 = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_LINE1 = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_LINE2 = 8'h94;
   localparam logic [BYTE_W-1:0] CMD_LINE3 = 8'hD4;
   localparam logic [BYTE_W-1:0] CMD_WAKE = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_FUNC_SET = 8'h38;
   localparam logic [BYTE_W-1:0] CMD_DISP_ON = 8'h0C;
   localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME = 8'h02;

   // init sequence steps; the wake-up triplet is skipped once powered on
   localparam logic [STEP_W-1:0] INIT_FIRST_STEP = 3'd0;
   localparam logic [STEP_W-1:0] INIT_WARM_STEP = 3'd3;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 3'd6;

   // character translation on write; cyrillic glyphs indexed by code minus 0xc0
   function automatic logic [BYTE_W-1:0] glyph(input logic [BYTE_W-1:0] code);
      logic [BYTE_W-1:0] result;
      if (code[7:6] == 2'b11) begin
         case (code[5:0])
            6'd0:  result = 8'h41;  6'd1:  result = 8'hA0;  6'd2:  result = 8'h42;
            6'd3:  result = 8'hA1;  6'd4:  result = 8'hE0;  6'd5:  result = 8'h45;
            6'd6:  result = 8'hA3;  6'd7:  result = 8'hA4;  6'd8:  result = 8'hA5;
            6'd9:  result = 8'hA6;  6'd10: result = 8'h4B;  6'd11: result = 8'hA7;
            6'd12: result = 8'h4D;  6'd13: result = 8'h48;  6'd14: result = 8'h4F;
            6'd15: result = 8'hA8;  6'd16: result = 8'h50;  6'd17: result = 8'h43;
            6'd18: result = 8'h54;  6'd19: result = 8'hA9;  6'd20: result = 8'hAA;
            6'd21: result = 8'h58;  6'd22: result = 8'hE1;  6'd23: result = 8'hAB;
            6'd24: result = 8'hAC;  6'd25: result = 8'hE2;  6'd26: result = 8'hAD;
            6'd27: result = 8'hAE;  6'd28: result = 8'h62;  6'd29: result = 8'hAF;
            6'd30: result = 8'hB0;  6'd31: result = 8'hB1;  6'd32: result = 8'h61;
            6'd33: result = 8'hB2;  6'd34: result = 8'hB3;  6'd35: result = 8'hB4;
            6'd36: result = 8'hE3;  6'd37: result = 8'h65;  6'd38: result = 8'hB6;
            6'd39: result = 8'hB7;  6'd40: result = 8'hB8;  6'd41: result = 8'hB9;
            6'd42: result = 8'hBA;  6'd43: result = 8'hBB;  6'd44: result = 8'hBC;
            6'd45: result = 8'hBD;  6'd46: result = 8'h6F;  6'd47: result = 8'hBE;
            6'd48: result = 8'h70;  6'd49: result = 8'h63;  6'd50: result = 8'hBF;
            6'd51: result = 8'h79;  6'd52: result = 8'hE4;  6'd53: result = 8'h78;
            6'd54: result = 8'hE5;  6'd55: result = 8'hC0;  6'd56: result = 8'hC1;
            6'd57: result = 8'hE6;  6'd58: result = 8'hC2;  6'd59: result = 8'hC3;
            6'd60: result = 8'hC4;  6'd61: result = 8'hC5;  6'd62: result = 8'hC6;
            default: result = 8'hC7;
         endcase
      end else begin
         result = code;
      end
      return result;
   endfunction

   // init command byte per step
   function automatic logic [BYTE_W-1:0] init_byte(input logic [STEP_W-1:0] step);
      logic [BYTE_W-1:0] result;
      unique case (step)
         3'd0, 3'd1, 3'd2: result = CMD_WAKE;
         3'd3:             result = CMD_FUNC_SET;
         3'd4:             result = CMD_DISP_ON;
         3'd5:             result = CMD_CLEAR;
         3'd6:             result = CMD_HOME;
         default:          result = CMD_HOME;
      endcase
      return result;
   endfunction

   // wait in microseconds before each init command
   function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
      logic [WAIT_W-1:0] result;
      unique case (step)
         3'd0:       result = 18'd200000;
         3'd1:       result = 18'd20000;
         3'd2:       result = 18'd200;
         3'd3, 3'd6: result = 18'd2000;
         3'd4, 3'd5: result = 18'd100;
         default:    result = 18'd2000;
      endcase
      return result;
   endfunction

endpackage

[rtl/char_lcd_refresh_engine.sv]
// char_lcd_refresh_engine: top level of the character lcd refresh engine
// depends on clre_pkg, clre_ctrl and clre_datapath
//
//   channel    ports                               transfer when
//   ---------  ----------------------------------  ------------------------
//   request    start, busy, req_mode/position/     start && !busy at clock
//              char_code
//   response   rsp_valid, rsp_is_data, rsp_bus_     rsp_valid (one cycle,
//              byte, rsp_wait_before_us, rsp_last,  cannot be held off)
//              rsp_refresh_busy
//
// a data tick is a registered read of the screen store, then the result.
// command ticks, idle ticks, writes, refresh start and clear leave the sequencer idle.
// init sends seven commands the first time and four after, one result per cycle from the sequencer.
// each result is registered and appears in the cycle after the cycle that produced it.
// reset is synchronous; the screen store reads as spaces right after reset.
// results are never stalled; busy is the only back pressure on requests.

module char_lcd_refresh_engine #(
   parameter int SCREEN_CHARS = 80,
   parameter int LINE_CHARS   = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [clre_pkg::MODE_W-1:0]   req_mode,
   input  logic [clre_pkg::POS_W-1:0]    req_position,
   input  logic [clre_pkg::BYTE_W-1:0]   req_char_code,
   output logic                          rsp_valid,
   output logic                          rsp_is_data,
   output logic [clre_pkg::BYTE_W-1:0]   rsp_bus_byte,
   output logic [clre_pkg::WAIT_W-1:0]   rsp_wait_before_us,
   output logic                          rsp_last,
   output logic                          rsp_refresh_busy
);

   clre_pkg::dp_cmd_type    dp_cmd;
   clre_pkg::dp_status_type dp_status;

   // sequencer
   clre_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (dp_status),
      .busy     (busy),
      .cmd      (dp_cmd)
   );

   // store and result datapath
   clre_datapath #(
      .SCREEN_CHARS (SCREEN_CHARS),
      .LINE_CHARS   (LINE_CHARS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_position       (req_position),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_is_data        (rsp_is_data),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_last           (rsp_last),
      .rsp_refresh_busy   (rsp_refresh_busy)
   );

   // a result only follows a request transfer or a sequencer cycle
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a preceding request or sequencer cycle");

   // data results come from the fetch cycle
   a_data_after_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data |-> $past(busy))
      else $error("data result without a store fetch");

   // init results run back to back until the last one
   a_init_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside the init command sequence");

   // the sequencer is free once the last init command shows
   a_init_done_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && (rsp_wait_before_us != '0) |-> !busy)
      else $error("sequencer still busy after the last init command");

endmodule

[rtl/clre_ctrl.sv]
// clre_ctrl: request sequencer, decodes modes and steps the init sequence
// depends on clre_pkg; drives clre_datapath through dp_cmd_type

module clre_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [clre_pkg::MODE_W-1:0]   req_mode,
   input  clre_pkg::dp_status_type       status,
   output logic                          busy,
   output clre_pkg::dp_cmd_type          cmd
);

   clre_pkg::ctl_state_type         state_ff, state_in;
   logic [clre_pkg::STEP_W-1:0]     step_ff, step_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clre_pkg::CTL_IDLE;
         step_ff  <= clre_pkg::INIT_FIRST_STEP;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      busy          = 1'b1;
      cmd.op        = clre_pkg::DP_NOP;
      cmd.power_on  = 1'b0;
      cmd.init_step = step_ff;
      unique case (state_ff)
         clre_pkg::CTL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_mode)
                  clre_pkg::MODE_TICK: begin
                     if (status.refresh_active) begin
                        if (status.cmd_pending) begin
                           cmd.op = clre_pkg::DP_SEND_PENDING;
                        end else begin
                           cmd.op   = clre_pkg::DP_FETCH;
                           state_in = clre_pkg::CTL_FETCH;
                        end
                     end
                  end
                  clre_pkg::MODE_WRITE:   cmd.op = clre_pkg::DP_WRITE_CHAR;
                  clre_pkg::MODE_REFRESH: cmd.op = clre_pkg::DP_START_REFRESH;
                  clre_pkg::MODE_CLEAR:   cmd.op = clre_pkg::DP_CLEAR;
                  clre_pkg::MODE_INIT: begin
                     cmd.power_on = 1'b1;
                     step_in      = status.powered_on ? clre_pkg::INIT_WARM_STEP
                                                      : clre_pkg::INIT_FIRST_STEP;
                     state_in     = clre_pkg::CTL_INIT;
                  end
                  default: ;
               endcase
            end
         end
         clre_pkg::CTL_FETCH: begin
            cmd.op   = clre_pkg::DP_SEND_DATA;
            state_in = clre_pkg::CTL_IDLE;
         end
         clre_pkg::CTL_INIT: begin
            cmd.op  = clre_pkg::DP_SEND_INIT;
            step_in = step_ff + 3'd1;
            if (step_ff == clre_pkg::INIT_LAST_STEP) begin
               state_in = clre_pkg::CTL_IDLE;
            end
         end
         default: state_in = clre_pkg::CTL_IDLE;
      endcase
   end

endmodule

[rtl/clre_datapath.sv]
// clre_datapath: screen store, scan pointer, pending line command and result registers
// depends on clre_pkg; commanded by clre_ctrl

module clre_datapath #(
   parameter int SCREEN_CHARS = 80,
   parameter int LINE_CHARS   = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  clre_pkg::dp_cmd_type          cmd,
   output clre_pkg::dp_status_type       status,
   input  logic [clre_pkg::POS_W-1:0]    req_position,
   input  logic [clre_pkg::BYTE_W-1:0]   req_char_code,
   output logic                          rsp_valid,
   output logic                          rsp_is_data,
   output logic [clre_pkg::BYTE_W-1:0]   rsp_bus_byte,
   output logic [clre_pkg::WAIT_W-1:0]   rsp_wait_before_us,
   output logic                          rsp_last,
   output logic                          rsp_refresh_busy
);

   localparam int IDX_W = $clog2(SCREEN_CHARS);
   localparam int CMP_W = 8;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCREEN_CHARS - 1);
   localparam logic [clre_pkg::POS_W-1:0] POS_LIMIT = clre_pkg::POS_W'(SCREEN_CHARS);
   localparam logic [CMP_W-1:0] LINE1_IDX = CMP_W'(LINE_CHARS);
   localparam logic [CMP_W-1:0] LINE2_IDX = CMP_W'(2 * LINE_CHARS);
   localparam logic [CMP_W-1:0] LINE3_IDX = CMP_W'(3 * LINE_CHARS);

   // screen store and per-entry valid bits (invalid reads as space)
   logic [clre_pkg::BYTE_W-1:0] store_mem [SCREEN_CHARS];
   logic [SCREEN_CHARS-1:0]     valid_ff, valid_in;
   logic [clre_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   logic [IDX_W-1:0]            scan_ff, scan_in;
   logic [clre_pkg::BYTE_W-1:0] pending_ff, pending_in;
   logic                        refresh_ff, refresh_in;
   logic                        powered_ff, powered_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_is_data_ff, rsp_is_data_in;
   logic [clre_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [clre_pkg::WAIT_W-1:0] rsp_wait_ff, rsp_wait_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_busy_ff, rsp_busy_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic                        scan_wrap;
   logic [IDX_W-1:0]            scan_step;
   logic [CMP_W-1:0]            scan_step_ext;

   assign wr_en   = (cmd.op == clre_pkg::DP_WRITE_CHAR) && (req_position < POS_LIMIT);
   assign wr_addr = req_position[IDX_W-1:0];

   // store write and registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= clre_pkg::glyph(req_char_code);
      end
      if (cmd.op == clre_pkg::DP_FETCH) begin
         rd_data_ff  <= store_mem[scan_ff];
         rd_valid_ff <= valid_ff[scan_ff];
      end
   end

   // valid bits: clear resets all entries to space at once
   always_comb begin
      valid_in = valid_ff;
      if (cmd.op == clre_pkg::DP_CLEAR) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // scan step with wrap at the end of the screen
   assign scan_wrap     = (scan_ff == LAST_IDX);
   assign scan_step     = scan_wrap ? '0 : scan_ff + IDX_W'(1);
   assign scan_step_ext = {{(CMP_W - IDX_W){1'b0}}, scan_step};

   // control next state and result loading
   always_comb begin
      scan_in        = scan_ff;
      pending_in     = pending_ff;
      refresh_in     = refresh_ff;
      powered_in     = powered_ff | cmd.power_on;
      rsp_valid_in   = 1'b0;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_busy_in    = rsp_busy_ff;
      case (cmd.op)
         clre_pkg::DP_START_REFRESH: refresh_in = 1'b1;
         clre_pkg::DP_SEND_PENDING: begin
            pending_in     = '0;
            rsp_valid_in   = 1'b1;
            rsp_is_data_in = 1'b0;
            rsp_byte_in    = pending_ff;
            rsp_wait_in    = '0;
            rsp_last_in    = 1'b1;
         end
         clre_pkg::DP_SEND_DATA: begin
            scan_in = scan_step;
            if (scan_wrap) begin
               refresh_in = 1'b0;
               pending_in = clre_pkg::CMD_LINE0;
            end else if (scan_step_ext == LINE1_IDX) begin
               pending_in = clre_pkg::CMD_LINE1;
            end else if (scan_step_ext == LINE2_IDX) begin
               pending_in = clre_pkg::CMD_LINE2;
            end else if (scan_step_ext == LINE3_IDX) begin
               pending_in = clre_pkg::CMD_LINE3;
            end
            rsp_valid_in   = 1'b1;
            rsp_is_data_in = 1'b1;
            rsp_byte_in    = rd_valid_ff ? rd_data_ff : clre_pkg::CHAR_SPACE;
            rsp_wait_in    = '0;
            rsp_last_in    = 1'b1;
         end
         clre_pkg::DP_SEND_INIT: begin
            rsp_valid_in   = 1'b1;
            rsp_is_data_in = 1'b0;
            rsp_byte_in    = clre_pkg::init_byte(cmd.init_step);
            rsp_wait_in    = clre_pkg::init_wait(cmd.init_step);
            rsp_last_in    = (cmd.init_step == clre_pkg::INIT_LAST_STEP);
         end
         default: ;
      endcase
      if (rsp_valid_in) begin
         rsp_busy_in = refresh_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         scan_ff      <= '0;
         pending_ff   <= '0;
         refresh_ff   <= 1'b0;
         powered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         pending_ff   <= pending_in;
         refresh_ff   <= refresh_in;
         powered_ff   <= powered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_busy_ff    <= rsp_busy_in;
   end

   assign status.refresh_active = refresh_ff;
   assign status.cmd_pending    = (pending_ff != '0);
   assign status.powered_on     = powered_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_data        = rsp_is_data_ff;
   assign rsp_bus_byte       = rsp_byte_ff;
   assign rsp_wait_before_us = rsp_wait_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_refresh_busy   = rsp_busy_ff;

endmodule
